>>> hdl/hec_pkg.sv
`default_nettype none
package hec_pkg;
    localparam int SYMBOLS_DEF     = 256;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int BYTE_BITS       = 8;
    localparam int OUT_W           = 19;
    localparam int DISTINCT_W      = 9;
    localparam logic [OUT_W-1:0] OUT_MAX = 19'd524280;
endpackage
`default_nettype wire

>>> hdl/hec_ram.sv
`default_nettype none
// simple dual-port RAM, registered read
module hec_ram #(
    parameter int DW    = 16,
    parameter int AW    = 8,
    parameter int DEPTH = 256
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hdl/huffman_encoded_size.sv
// Sequence: bytes load while in_stall is low; after the last byte, a drain state,
//   a histogram sweep over every bin, a setup state, per merge a scan of the list
//   (plus a tail move when needed), and a final state to register the result.
// Throughput: one byte per cycle inside a message; in_stall stays high from the
//   last byte until the result transaction completes.
// Reset: rst_n async low; clears sequencer, counters and histogram valid bits.
`default_nettype none
module huffman_encoded_size #(
    parameter int SYMBOLS     = hec_pkg::SYMBOLS_DEF,
    parameter int COUNT_WIDTH = hec_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         symbol,
    input  wire logic                               last,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [hec_pkg::OUT_W-1:0]               raw_bits,
    output logic [hec_pkg::OUT_W-1:0]               coded_bits,
    output logic [hec_pkg::DISTINCT_W-1:0]          distinct_symbols,
    output logic                                    overflow
);
    localparam int CW = COUNT_WIDTH;
    localparam int SW = $clog2(SYMBOLS);
    localparam int NW = $clog2(SYMBOLS + 1);
    localparam int TW = CW + SW;                  // merged-weight total
    localparam int BS = $clog2(hec_pkg::BYTE_BITS);
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    typedef enum logic [3:0] {
        S_RUN, S_DRAIN, S_LOAD, S_LEND, S_PREP,
        S_SCAN, S_SEND, S_FIX, S_MOVE, S_DONE, S_OUT
    } state_t;

    state_t state_reg;

    // histogram: RAM plus per-bin valid bits (cleared at once per message)
    logic [SYMBOLS-1:0] vbits_reg;
    logic               hv_reg;
    logic [SW-1:0]      h_raddr, h_waddr;
    logic [CW-1:0]      h_rdata, h_wdata;
    logic               h_we;

    // byte pipeline: read at accept, write in the next cycle
    logic               p_valid_reg, p_cnt_reg, fwd_reg;
    logic [SW-1:0]      p_sym_reg;
    logic [CW-1:0]      fwd_val_reg, cur_cnt;

    logic [CW-1:0]      len_reg;
    logic               ovf_reg;

    // weight list
    logic [SW-1:0]      w_raddr, w_waddr;
    logic [CW-1:0]      w_rdata, w_wdata;
    logic               w_we;
    logic [NW-1:0]      n_reg, n_dec;
    logic [SW-1:0]      ld_addr_reg, last_idx;
    logic               ld_p_reg, ld_hit;

    // min search
    logic [SW-1:0]      sc_idx_reg, sc_pidx_reg, i1_reg, i2_reg;
    logic               sc_p_reg;
    logic [CW:0]        m1_reg, m2_reg, d_ext;
    logic [CW-1:0]      sum;
    logic [TW-1:0]      total_reg;

    logic               accept, do_count;
    logic [SW-1:0]      sym_c;
    logic [CW+BS-1:0]   raw_wide;

    logic [hec_pkg::OUT_W-1:0] raw_reg, coded_reg;
    logic [hec_pkg::DISTINCT_W-1:0] dist_reg;
    logic               ovf_out_reg, out_valid_reg;

    assign in_stall = (state_reg != S_RUN);
    assign accept   = in_valid && !in_stall;
    assign do_count = (len_reg != COUNT_MAX);
    // out-of-range symbols fold into the top bin
    assign sym_c    = (9'(symbol) >= 9'(SYMBOLS)) ? SW'(SYMBOLS - 1) : SW'(symbol);

    assign cur_cnt  = fwd_reg ? fwd_val_reg : (hv_reg ? h_rdata : '0);
    assign h_we     = p_valid_reg && p_cnt_reg;
    assign h_waddr  = p_sym_reg;
    assign h_wdata  = cur_cnt + CW'(1);
    assign h_raddr  = (state_reg == S_RUN) ? sym_c : ld_addr_reg;

    assign n_dec    = n_reg - NW'(1);
    assign last_idx = n_dec[SW-1:0];
    assign ld_hit   = ld_p_reg && hv_reg && (h_rdata != '0);
    assign d_ext    = {1'b0, w_rdata};
    assign sum      = m1_reg[CW-1:0] + m2_reg[CW-1:0];
    assign raw_wide = (CW+BS)'(len_reg) << BS;

    hec_ram #(.DW(CW), .AW(SW), .DEPTH(SYMBOLS)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    hec_ram #(.DW(CW), .AW(SW), .DEPTH(SYMBOLS)) u_wlist (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    // weight list port: sweep capture, merge write-back, tail move
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = n_reg[SW-1:0];
        w_wdata = h_rdata;
        w_raddr = sc_idx_reg;
        if (ld_hit)
        begin
            w_we = 1'b1;
        end
        case (state_reg)
            S_FIX:
            begin
                w_raddr = last_idx;
                w_we    = 1'b1;
                w_wdata = sum;
                w_waddr = (i1_reg == last_idx) ? i2_reg : i1_reg;
            end
            S_MOVE:
            begin
                w_we    = 1'b1;
                w_waddr = i2_reg;
                w_wdata = w_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            vbits_reg     <= '0;
            p_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            ld_p_reg      <= 1'b0;
            sc_p_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hv_reg      <= vbits_reg[h_raddr];
            p_valid_reg <= accept;
            p_cnt_reg   <= do_count;
            p_sym_reg   <= sym_c;
            // back-to-back hit on the bin being written this edge
            fwd_reg     <= accept && do_count && h_we && (sym_c == p_sym_reg);
            fwd_val_reg <= h_wdata;
            if (h_we)
            begin
                vbits_reg[p_sym_reg] <= 1'b1;
            end

            ld_p_reg <= (state_reg == S_LOAD);
            if (ld_hit)
            begin
                n_reg <= n_reg + NW'(1);
            end

            sc_p_reg    <= (state_reg == S_SCAN);
            sc_pidx_reg <= sc_idx_reg;
            if (sc_p_reg)
            begin
                if (d_ext < m1_reg)
                begin
                    m2_reg <= m1_reg;
                    i2_reg <= i1_reg;
                    m1_reg <= d_ext;
                    i1_reg <= sc_pidx_reg;
                end
                else if (d_ext < m2_reg)
                begin
                    m2_reg <= d_ext;
                    i2_reg <= sc_pidx_reg;
                end
            end

            case (state_reg)
                S_RUN:
                begin
                    if (accept)
                    begin
                        if (do_count)
                            len_reg <= len_reg + CW'(1);
                        else
                            ovf_reg <= 1'b1;
                        if (last)
                        begin
                            ld_addr_reg <= '0;
                            state_reg   <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: state_reg <= S_LOAD;
                S_LOAD:
                begin
                    ld_addr_reg <= ld_addr_reg + SW'(1);
                    if (ld_addr_reg == SW'(SYMBOLS - 1))
                        state_reg <= S_LEND;
                end
                S_LEND: state_reg <= S_PREP;
                S_PREP:
                begin
                    // distinct count before the merges shrink the list
                    dist_reg <= hec_pkg::DISTINCT_W'(n_reg);
                    if (n_reg > NW'(1))
                    begin
                        total_reg  <= '0;
                        sc_idx_reg <= '0;
                        m1_reg     <= '1;
                        m2_reg     <= '1;
                        state_reg  <= S_SCAN;
                    end
                    else
                    begin
                        // single symbol: one bit per byte
                        total_reg <= TW'(len_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    sc_idx_reg <= sc_idx_reg + SW'(1);
                    if (sc_idx_reg == last_idx)
                        state_reg <= S_SEND;
                end
                S_SEND: state_reg <= S_FIX;
                S_FIX:
                begin
                    total_reg <= total_reg + TW'(sum);
                    if ((i1_reg == last_idx) || (i2_reg == last_idx))
                    begin
                        n_reg      <= n_dec;
                        sc_idx_reg <= '0;
                        m1_reg     <= '1;
                        m2_reg     <= '1;
                        state_reg  <= (n_dec > NW'(1)) ? S_SCAN : S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_MOVE;
                    end
                end
                S_MOVE:
                begin
                    n_reg      <= n_dec;
                    sc_idx_reg <= '0;
                    m1_reg     <= '1;
                    m2_reg     <= '1;
                    state_reg  <= (n_dec > NW'(1)) ? S_SCAN : S_DONE;
                end
                S_DONE:
                begin
                    raw_reg       <= (64'(raw_wide) > 64'(hec_pkg::OUT_MAX)) ?
                                     hec_pkg::OUT_MAX : hec_pkg::OUT_W'(raw_wide);
                    coded_reg     <= (64'(total_reg) > 64'(hec_pkg::OUT_MAX)) ?
                                     hec_pkg::OUT_MAX : hec_pkg::OUT_W'(total_reg);
                    ovf_out_reg   <= ovf_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        vbits_reg     <= '0;
                        len_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        n_reg         <= '0;
                        state_reg     <= S_RUN;
                    end
                end
                default: state_reg <= S_RUN;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign raw_bits         = raw_reg;
    assign coded_bits       = coded_reg;
    assign distinct_symbols = dist_reg;
    assign overflow         = ovf_out_reg;
endmodule
`default_nettype wire

>>> hdl/hec_checker.sv
`default_nettype none
module hec_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [18:0] raw_bits,
    input wire logic [18:0] coded_bits,
    input wire logic [8:0]  distinct_symbols,
    input wire logic        overflow
);
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated");

    a_raw_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (raw_bits[2:0] == 3'd0) && (distinct_symbols != 9'd0))
        else $error("bad raw size or symbol count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(coded_bits)
            && $stable(overflow))
        else $error("stalled result changed");
endmodule

bind huffman_encoded_size hec_checker u_hec_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .raw_bits(raw_bits),
    .coded_bits(coded_bits), .distinct_symbols(distinct_symbols),
    .overflow(overflow)
);
`default_nettype wire

>>> test/huffman_encoded_size_test.sv
`default_nettype none
// Testbench for huffman_encoded_size.
// Messages are driven one byte per transaction. A local histogram follows every
// accepted byte; on the final byte it works out the raw size, the Huffman-coded
// size (sum of merged weights), the distinct count and the overflow flag, and queues
// that, or a typed row's given result, as expected. Results are compared in order.
module huffman_encoded_size_test;
    localparam int COUNT_MAX = (1 << hec_pkg::COUNT_WIDTH_DEF) - 1;
    localparam int WATCHDOG  = 400000;

    typedef struct packed {
        logic [hec_pkg::OUT_W-1:0]      raw;
        logic [hec_pkg::OUT_W-1:0]      coded;
        logic [hec_pkg::DISTINCT_W-1:0] distinct;
        logic                           ovf;
    } size_result_t;

    // One directed row: a byte repeated (or swept) reps times, last on the final one if set.
    typedef struct {
        logic [7:0]   sym;
        bit           last;
        int           reps;
        bit           sweep;
        bit           typed;
        size_result_t want;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [7:0]                     symbol;
    logic                           last;
    logic                           out_valid;
    logic                           out_stall;
    logic [hec_pkg::OUT_W-1:0]      raw_bits;
    logic [hec_pkg::OUT_W-1:0]      coded_bits;
    logic [hec_pkg::DISTINCT_W-1:0] distinct_symbols;
    logic                           overflow;

    // typed expectation that travels with the current byte
    logic                  item_typed;
    size_result_t          item_want;

    huffman_encoded_size dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .symbol           (symbol),
        .last             (last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .raw_bits         (raw_bits),
        .coded_bits       (coded_bits),
        .distinct_symbols (distinct_symbols),
        .overflow         (overflow)
    );

    // predictor state
    int           hist [hec_pkg::SYMBOLS_DEF];
    int           msg_len;
    bit           len_capped;
    size_result_t size_queue [$];

    int  mismatches;
    int  idle_cycles;
    int  stall_left;
    bit  stall_busy;   // when set, out_stall is exercised

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sum of all merged weights over the nonzero histogram bins, with raw, distinct, ovf.
    function automatic size_result_t size_of_message();
        longint       w [$];
        longint       total;
        longint       a;
        longint       b;
        longint       raw;
        int           lo;
        size_result_t r;
        total = 0;
        foreach (hist[s])
            if (hist[s] != 0)
                w.push_back(hist[s]);
        r.distinct = hec_pkg::DISTINCT_W'(w.size());
        if (w.size() == 1)
            total = msg_len;   // lone symbol: one bit per byte
        else
            while (w.size() > 1)
            begin
                lo = 0;
                foreach (w[i])
                    if (w[i] < w[lo])
                        lo = i;
                a = w[lo];
                w.delete(lo);
                lo = 0;
                foreach (w[i])
                    if (w[i] < w[lo])
                        lo = i;
                b = w[lo];
                w.delete(lo);
                w.push_back(a + b);
                total += a + b;
            end
        raw     = longint'(msg_len) * hec_pkg::BYTE_BITS;
        r.raw   = (raw > hec_pkg::OUT_MAX) ? hec_pkg::OUT_MAX : raw[hec_pkg::OUT_W-1:0];
        r.coded = (total > hec_pkg::OUT_MAX) ? hec_pkg::OUT_MAX : total[hec_pkg::OUT_W-1:0];
        r.ovf   = len_capped;
        return r;
    endfunction

    // Accept-side bookkeeping, result checking and the watchdog, all at the rising edge.
    always @(posedge clk)
    begin
        size_result_t got;
        size_result_t exp_r;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                if (msg_len >= COUNT_MAX)
                    len_capped = 1'b1;
                else
                begin
                    hist[symbol]++;
                    msg_len++;
                end
                if (last)
                begin
                    exp_r = size_of_message();
                    if (item_typed)
                        exp_r = item_want;
                    size_queue.push_back(exp_r);
                    foreach (hist[s])
                        hist[s] = 0;
                    msg_len    = 0;
                    len_capped = 1'b0;
                end
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got = '{raw_bits, coded_bits, distinct_symbols, overflow};
                if (size_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result raw=%0d coded=%0d distinct=%0d ovf=%0d",
                                 raw_bits, coded_bits, distinct_symbols, overflow);
                end
                else
                begin
                    exp_r = size_queue.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp raw=%0d coded=%0d distinct=%0d ovf=%0d,",
                                      " got raw=%0d coded=%0d distinct=%0d ovf=%0d"},
                                     exp_r.raw, exp_r.coded, exp_r.distinct, exp_r.ovf,
                                     got.raw, got.coded, got.distinct, got.ovf);
                    end
                end
            end
            if (moved)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, mostly short, a few long, with calm stretches.
    always @(negedge clk)
    begin
        if (!rst_n || !stall_busy)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(0, 99) < 30)
        begin
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    // Drive one byte; waits for the transaction, then leaves in_valid high.
    task automatic send_byte(input logic [7:0] s, input bit l, input bit typed,
                             input size_result_t want);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < 25)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        symbol     <= s;
        last       <= l;
        item_typed <= typed;
        item_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Directed stimulus: extremes, the lone-symbol case, a full sweep.
    stim_row_t rows [16] = '{
        '{8'hFF, 1, 1,     0, 1, '{19'd8,    19'd1,     9'd1,   1'b0}},
        '{8'h00, 1, 1,     0, 1, '{19'd8,    19'd1,     9'd1,   1'b0}},
        '{8'h00, 0, 1,     0, 0, '0},
        '{8'hFF, 1, 1,     0, 1, '{19'd16,   19'd2,     9'd2,   1'b0}},
        '{8'h03, 0, 4,     0, 0, '0},
        '{8'h07, 0, 2,     0, 0, '0},
        '{8'h09, 1, 1,     0, 0, '0},
        '{8'hAA, 1, 5,     0, 1, '{19'd40,   19'd5,     9'd1,   1'b0}},
        '{8'h00, 1, 256,   1, 1, '{19'd2048, 19'd2048,  9'd256, 1'b0}},
        '{8'h01, 0, 3,     0, 0, '0},
        '{8'h02, 1, 3,     0, 0, '0},
        '{8'h55, 0, 17,    0, 0, '0},
        '{8'h80, 0, 1,     0, 0, '0},
        '{8'h7F, 1, 9,     0, 0, '0},
        '{8'h12, 0, 2,     0, 0, '0},
        '{8'h34, 1, 1,     0, 0, '0}
    };

    initial
    begin
        int           len;
        int           alpha;
        int           base;
        int           sent;
        logic [7:0]   s;
        bit           fin;
        size_result_t none;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        symbol      = '0;
        last        = 1'b0;
        out_stall   = 1'b0;
        item_typed  = 1'b0;
        item_want   = '0;
        none        = '0;
        mismatches  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        stall_busy  = 1'b0;
        msg_len     = 0;
        len_capped  = 1'b0;
        foreach (hist[i])
            hist[i] = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[r])
        begin
            stall_busy = (r % 3 == 1);
            for (int k = 0; k < rows[r].reps; k++)
            begin
                s   = rows[r].sweep ? rows[r].sym + k[7:0] : rows[r].sym;
                fin = rows[r].last && (k == rows[r].reps - 1);
                send_byte(s, fin, fin && rows[r].typed, rows[r].want);
            end
        end

        // Random messages: small alphabets, full range, skewed, a few long ones.
        sent = 0;
        while (sent < 400)
        begin
            stall_busy = ($urandom_range(0, 3) != 0);
            len   = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 300)
                                                 : $urandom_range(1, 20);
            alpha = $urandom_range(0, 3);
            base  = $urandom_range(0, 255);
            for (int k = 0; k < len; k++)
            begin
                case (alpha)
                    0:       s = 8'($urandom_range(0, 255));
                    1:       s = 8'(base + $urandom_range(0, 3));
                    2:       s = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'(base);
                    default: s = 8'(base ^ (1 << $urandom_range(0, 7)) * $urandom_range(0, 1));
                endcase
                send_byte(s, k == len - 1, 1'b0, none);
            end
            sent += len;
        end
        in_valid <= 1'b0;
        last     <= 1'b0;

        while (size_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
